// ===== design/mps_pkg.sv =====
`default_nettype none
package mps_pkg;
    localparam int PaletteSize = 64;
    localparam int MaxInfl = 4;
    localparam int ElemsPerMat = 12;
    localparam int PalDepth = PaletteSize * ElemsPerMat;
    localparam int PalAw = $clog2(PalDepth);
    localparam int MatW = 6;
    localparam int SlotW = 2;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SLOT = 2'd1;
    localparam logic [1:0] CMD_POINT = 2'd2;
    localparam logic [1:0] CMD_NORMAL = 2'd3;

    typedef struct packed {
        logic               point;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t[63:16];
    endfunction
endpackage
`default_nettype wire

// ===== design/mps_ram.sv =====
`default_nettype none
module mps_ram #(
    parameter int Width = 32,
    parameter int Depth = 768
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/mps_front.sv =====
`default_nettype none
module mps_front import mps_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire [1:0]        i_cmd,
    input  wire [MatW-1:0]   i_matrix_sel,
    input  wire [3:0]        i_element_sel,
    input  wire [SlotW-1:0]  i_slot_sel,
    input  wire [31:0]       i_value,
    input  wire [31:0]       i_vec_x,
    input  wire [31:0]       i_vec_y,
    input  wire [31:0]       i_vec_z,
    input  wire              i_back_idle,
    output logic             o_pal_we,
    output logic [PalAw-1:0] o_pal_waddr,
    output logic [31:0]      o_pal_wdata,
    output logic             o_slot_we,
    output logic             o_job_valid,
    output t_job             o_job,
    input  wire              i_job_ready
);
    // Two-entry queue of transform jobs toward the back end.
    t_job r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic r_rd, r_wr;
    logic is_xf, push, pop;
    t_job in_job;

    assign is_xf = i_cmd == CMD_POINT || i_cmd == CMD_NORMAL;
    // Palette and slot writes wait until every earlier transform has finished.
    assign o_ready = is_xf ? r_cnt != 2'd2 : (r_cnt == 2'd0 && i_back_idle);
    assign push = i_valid && o_ready && is_xf;
    assign pop = o_job_valid && i_job_ready;
    assign o_job_valid = r_cnt != 2'd0;
    assign o_job = r_q[r_rd];
    assign in_job = '{point: i_cmd == CMD_POINT, x: i_vec_x, y: i_vec_y, z: i_vec_z};

    assign o_pal_we = i_valid && o_ready && i_cmd == CMD_LOAD && i_element_sel < 4'd12
        && 32'(i_matrix_sel) < 32'(PaletteSize);
    assign o_pal_waddr = PalAw'(i_matrix_sel) * PalAw'(ElemsPerMat) + PalAw'(i_element_sel);
    assign o_pal_wdata = i_value;
    assign o_slot_we = i_valid && o_ready && i_cmd == CMD_SLOT
        && 32'(i_slot_sel) < 32'(MaxInfl);

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
        end
        if (push) begin
            r_q[r_wr] <= in_job;
        end
    end
endmodule
`default_nettype wire

// ===== design/mps_back.sv =====
`default_nettype none
module mps_back import mps_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_slot_we,
    input  wire [SlotW-1:0]  i_slot_sel,
    input  wire              i_slot_used,
    input  wire [MatW-1:0]   i_matrix_sel,
    input  wire [31:0]       i_value,
    input  wire              i_job_valid,
    input  t_job             i_job,
    output logic             o_job_ready,
    output logic [PalAw-1:0] o_pal_raddr,
    input  wire [31:0]       i_pal_rdata,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [31:0]      o_out_x,
    output logic [31:0]      o_out_y,
    output logic [31:0]      o_out_z
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN = 3'd1;
    localparam logic [2:0] ST_WGT = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic [31:0]     r_w [MaxInfl];
    logic [MatW-1:0] r_m [MaxInfl];
    logic            r_act [MaxInfl];

    logic [2:0]  r_st;
    t_job        r_job;
    logic [SlotW-1:0] r_slot;
    logic [3:0]  r_ea;          // element address issued
    logic        r_dv;          // data valid for element r_ed
    logic [3:0]  r_ed;
    logic        r_zero;        // matrix out of range
    logic signed [49:0] r_t [3];
    logic signed [49:0] r_acc [3];
    logic [1:0]  r_wc;
    logic signed [63:0] r_prod;
    logic        r_pv;
    logic [1:0]  r_pc;          // component of product
    logic        r_ptr;         // product is a translation add
    logic        r_pw;          // product is weighted
    logic signed [31:0] elem, vsel;
    logic [1:0] ecol;
    logic [1:0] erow;
    logic last_slot;

    assign o_pal_raddr = PalAw'(r_m[r_slot]) * PalAw'(ElemsPerMat) + PalAw'(r_ea);
    assign elem = r_zero ? 32'sd0 : $signed(i_pal_rdata);
    assign last_slot = 32'(r_slot) == MaxInfl - 1 || !r_act[SlotW'(32'(r_slot) + 1)];
    assign o_job_ready = r_st == ST_IDLE;

    always_comb begin
        if (r_ed >= 4'd9) begin
            erow = 2'd3;
            ecol = 2'(r_ed - 4'd9);
        end else if (r_ed >= 4'd6) begin
            erow = 2'd2;
            ecol = 2'(r_ed - 4'd6);
        end else if (r_ed >= 4'd3) begin
            erow = 2'd1;
            ecol = 2'(r_ed - 4'd3);
        end else begin
            erow = 2'd0;
            ecol = 2'(r_ed);
        end
    end

    always_comb begin
        case (erow)
            2'd0: vsel = r_job.x;
            2'd1: vsel = r_job.y;
            default: vsel = r_job.z;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            o_valid <= 1'b0;
            r_dv <= 1'b0;
            r_pv <= 1'b0;
            for (int i = 0; i < MaxInfl; i++) begin
                r_w[i] <= '0;
                r_m[i] <= '0;
                r_act[i] <= 1'b0;
            end
        end else begin
            if (i_slot_we) begin
                r_w[i_slot_sel] <= i_value;
                r_m[i_slot_sel] <= i_matrix_sel;
                r_act[i_slot_sel] <= i_slot_used;
            end
            if (o_valid && i_ready && r_st != ST_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_slot <= '0;
                        r_ea <= '0;
                        for (int c = 0; c < 3; c++) begin
                            r_acc[c] <= '0;
                            r_t[c] <= '0;
                        end
                        r_st <= r_act[0] ? ST_RUN : ST_DONE;
                    end
                end
                ST_RUN: begin
                    r_zero <= 32'(r_m[r_slot]) >= PaletteSize;
                    r_dv <= r_ea != 4'd12;
                    r_pv <= r_dv;
                    if (r_ea != 4'd12) begin
                        r_ed <= r_ea;
                        r_ea <= r_ea + 4'd1;
                    end
                    if (r_dv) begin
                        r_pc <= ecol;
                        r_pw <= 1'b0;
                        r_ptr <= erow == 2'd3;
                        r_prod <= (erow == 2'd3) ? 64'(elem) : 64'(vsel) * 64'(elem);
                    end
                    if (r_pv) begin
                        if (r_ptr) begin
                            if (r_job.point) begin
                                r_t[r_pc] <= r_t[r_pc] + 50'(r_prod);
                            end
                        end else begin
                            r_t[r_pc] <= r_t[r_pc] + 50'(rnd16(r_prod));
                        end
                    end
                    if (r_ea == 4'd12 && !r_dv && !r_pv) begin
                        r_st <= ST_WGT;
                        r_wc <= '0;
                    end
                end
                ST_WGT: begin
                    r_pv <= r_wc != 2'd3;
                    if (r_wc != 2'd3) begin
                        r_prod <= 64'(sat32(r_t[r_wc])) * 64'($signed(r_w[r_slot]));
                        r_pc <= r_wc;
                        r_wc <= r_wc + 2'd1;
                    end
                    if (r_pv) begin
                        r_acc[r_pc] <= r_acc[r_pc] + 50'(rnd16(r_prod));
                    end
                    if (r_wc == 2'd3 && !r_pv) begin
                        for (int c = 0; c < 3; c++) begin
                            r_t[c] <= '0;
                        end
                        if (last_slot) begin
                            r_st <= ST_DONE;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                            r_ea <= '0;
                            r_st <= ST_RUN;
                        end
                    end
                end
                ST_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_out_x <= sat32(r_acc[0]);
                        o_out_y <= sat32(r_acc[1]);
                        o_out_z <= sat32(r_acc[2]);
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/matrix_palette_skinning_unit.sv =====
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | i_valid / o_ready   | i_cmd .. i_vec_z
// out     | output    | o_valid / i_ready   | o_out_x, o_out_y, o_out_z
// Palette loads and slot writes give no item out, but they wait until the job
// queue is empty and the back end is idle.
// A transform takes the job, works through each used influence in turn, one product
// at a time, over the single palette read port, and then issues the result.
// Reset is synchronous; the palette is undefined until written.
// A two-entry job queue lets transform items proceed while the back end or output stalls.
module matrix_palette_skinning_unit import mps_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [1:0]   i_cmd,
    input  wire [5:0]   i_matrix_sel,
    input  wire [3:0]   i_element_sel,
    input  wire [1:0]   i_slot_sel,
    input  wire         i_slot_used,
    input  wire [31:0]  i_value,
    input  wire [31:0]  i_vec_x,
    input  wire [31:0]  i_vec_y,
    input  wire [31:0]  i_vec_z,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z
);
    logic pal_we, slot_we, job_valid, job_ready;
    logic [PalAw-1:0] waddr, raddr;
    logic [31:0] wdata, rdata;
    t_job job;

    mps_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd, .i_matrix_sel, .i_element_sel,
        .i_slot_sel, .i_value, .i_vec_x, .i_vec_y, .i_vec_z,
        .i_back_idle(job_ready),
        .o_pal_we(pal_we), .o_pal_waddr(waddr), .o_pal_wdata(wdata),
        .o_slot_we(slot_we), .o_job_valid(job_valid), .o_job(job),
        .i_job_ready(job_ready)
    );

    mps_ram #(.Width(32), .Depth(PalDepth)) u_ram (
        .i_clk, .i_we(pal_we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    mps_back u_back (
        .i_clk, .i_rst_n, .i_slot_we(slot_we), .i_slot_sel,
        .i_slot_used, .i_matrix_sel, .i_value, .i_job_valid(job_valid),
        .i_job(job), .o_job_ready(job_ready), .o_pal_raddr(raddr),
        .i_pal_rdata(rdata), .o_valid, .i_ready, .o_out_x, .o_out_y, .o_out_z
    );
endmodule
`default_nettype wire

// ===== tb/matrix_palette_skinning_unit_test.sv =====
`timescale 1ns / 1ps
module matrix_palette_skinning_unit_test;
    import mps_pkg::*;

    class skin_scoreboard;
        bit [31:0] palette[768];
        bit [31:0] weight[4];
        bit [5:0]  matrix[4];
        bit        active[4];
        bit [95:0] pending_vectors[$];
        int        errors;

        function longint round_q16(longint p);
            return (p + 64'sd32768) >>> 16;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint element(int m, int e);
            return longint'($signed(palette[m * 12 + e]));
        endfunction

        function void note_input(logic [1:0] cmd, logic [5:0] msel, logic [3:0] esel,
                                 logic [1:0] ssel, logic used, logic [31:0] value,
                                 logic [31:0] x, logic [31:0] y, logic [31:0] z);
            longint v[3];
            longint acc[3];
            longint t;
            longint w;
            int m;
            bit [95:0] result;
            if (cmd == CMD_LOAD) begin
                if (esel < 12) palette[msel * 12 + esel] = value;
                return;
            end
            if (cmd == CMD_SLOT) begin
                weight[ssel] = value;
                matrix[ssel] = msel;
                active[ssel] = used;
                return;
            end
            v[0] = longint'($signed(x));
            v[1] = longint'($signed(y));
            v[2] = longint'($signed(z));
            acc = '{0, 0, 0};
            for (int s = 0; s < 4; s++) begin
                if (!active[s]) break;
                m = matrix[s];
                w = longint'($signed(weight[s]));
                for (int c = 0; c < 3; c++) begin
                    t = round_q16(v[0] * element(m, c)) + round_q16(v[1] * element(m, 3 + c))
                        + round_q16(v[2] * element(m, 6 + c));
                    if (cmd == CMD_POINT) t += element(m, 9 + c);
                    t = clamp32(t);
                    acc[c] += round_q16(t * w);
                end
            end
            for (int c = 0; c < 3; c++) result[32 * c +: 32] = 32'(clamp32(acc[c]));
            pending_vectors.push_back(result);
        endfunction

        function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z);
            bit [95:0] want;
            if (pending_vectors.size() == 0) begin
                $error("Unexpected result x=%h y=%h z=%h", x, y, z);
                errors++;
                return;
            end
            want = pending_vectors.pop_front();
            if (x !== want[31:0]) begin
                $error("out_x expected %h actual %h", want[31:0], x);
                errors++;
            end
            if (y !== want[63:32]) begin
                $error("out_y expected %h actual %h", want[63:32], y);
                errors++;
            end
            if (z !== want[95:64]) begin
                $error("out_z expected %h actual %h", want[95:64], z);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [5:0]  i_matrix_sel;
    logic [3:0]  i_element_sel;
    logic [1:0]  i_slot_sel;
    logic        i_slot_used;
    logic [31:0] i_value;
    logic [31:0] i_vec_x;
    logic [31:0] i_vec_y;
    logic [31:0] i_vec_z;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic [31:0] o_out_z;

    skin_scoreboard sb = new();
    bit [11:0] loaded[64];
    int        full_matrices[$];
    bit        quiet;
    int        idle_cycles = 0;

    matrix_palette_skinning_unit uut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_input(i_cmd, i_matrix_sel, i_element_sel, i_slot_sel, i_slot_used,
                          i_value, i_vec_x, i_vec_y, i_vec_z);
        end
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_out_x, o_out_y, o_out_z);
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= 5000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00010000;
            3: return 32'hffff0000;
            4: return 32'h0;
            5: return $urandom();
            default: return $urandom_range(0, 32'h40000) - 32'h20000;
        endcase
    endfunction

    function logic [31:0] pick_weight();
        if ($urandom_range(0, 7) == 0) return pick_value();
        return $urandom_range(0, 32'h20000) - 32'h8000;
    endfunction

    task automatic send(logic [1:0] cmd, logic [5:0] msel, logic [3:0] esel,
                        logic [1:0] ssel, logic used, logic [31:0] value,
                        logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_matrix_sel <= msel;
        i_element_sel <= esel;
        i_slot_sel <= ssel;
        i_slot_used <= used;
        i_value <= value;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic load(logic [5:0] m, logic [3:0] e, logic [31:0] value);
        send(CMD_LOAD, m, e, 2'($urandom()), 1'($urandom()), value, $urandom(), $urandom(),
             $urandom());
        if (e < 12 && loaded[m] != 12'hfff) begin
            loaded[m][e] = 1'b1;
            if (loaded[m] == 12'hfff) full_matrices.push_back(m);
        end
    endtask

    task automatic set_slot(logic [1:0] s, logic used, logic [5:0] m, logic [31:0] w);
        send(CMD_SLOT, m, 4'($urandom()), s, used, w, $urandom(), $urandom(), $urandom());
    endtask

    task automatic transform(logic [1:0] cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send(cmd, 6'($urandom()), 4'($urandom()), 2'($urandom()), 1'($urandom()), $urandom(),
             x, y, z);
    endtask

    function logic [5:0] pick_full();
        return 6'(full_matrices[$urandom_range(0, full_matrices.size() - 1)]);
    endfunction

    initial begin
        int hold_at;
        i_ready = 1'b0;
        hold_at = 4000;
        @(posedge i_rst_n);
        forever begin
            int gap;
            hold_at--;
            if (hold_at == 0) begin
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        logic [1:0] cmd;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_LOAD;
        i_matrix_sel = 0;
        i_element_sel = 0;
        i_slot_sel = 0;
        i_slot_used = 0;
        i_value = 0;
        i_vec_x = 0;
        i_vec_y = 0;
        i_vec_z = 0;
        quiet = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first slot is unused after reset, so the result is the zero vector.
        transform(CMD_POINT, 32'h7fffffff, 32'h80000000, 32'h00010000);
        for (int m = 0; m < 3; m++) begin
            for (int e = 0; e < 12; e++) begin
                load(6'(m), 4'(e), (e % 4 == 0) ? 32'h00010000 : pick_value());
            end
        end
        for (int e = 0; e < 12; e++) load(63, 4'(e), e[0] ? 32'h80000000 : 32'h7fffffff);
        load(5, 12, 32'h12345678);
        load(5, 15, 32'h9abcdef0);
        set_slot(0, 1, 0, 32'h00010000);
        set_slot(1, 1, 63, 32'h7fffffff);
        set_slot(2, 0, 40, 32'h80000000);
        set_slot(3, 1, 1, 32'h00008000);
        transform(CMD_POINT, 32'h00010000, 32'hffff0000, 32'h00020000);
        transform(CMD_NORMAL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        transform(CMD_POINT, 32'h80000000, 32'h80000000, 32'h80000000);
        set_slot(2, 1, 2, 32'h80000000);
        set_slot(3, 1, 0, 32'hffff8000);
        transform(CMD_POINT, 32'h0, 32'h0, 32'h0);
        transform(CMD_NORMAL, $urandom(), $urandom(), $urandom());
        set_slot(1, 0, 63, 32'h1);
        transform(CMD_NORMAL, 32'h00030000, 32'hfffd0000, 32'h00001234);
        set_slot(0, 0, 2, 32'h00010000);
        transform(CMD_POINT, 32'h00030000, 32'h00040000, 32'h00050000);

        for (int n = 0; n < 1085; n++) begin
            if (n % 200 == 100) quiet = 1'b1;
            if (n % 200 == 160) quiet = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2: load(6'($urandom()), 4'($urandom_range(0, 99) < 90 ?
                              $urandom_range(0, 11) : $urandom_range(12, 15)), pick_value());
                3, 4: begin
                    if ($urandom_range(0, 5) == 0) begin
                        set_slot(2'($urandom()), 0, 6'($urandom()), $urandom());
                    end else begin
                        set_slot(2'($urandom()), 1, pick_full(), pick_weight());
                    end
                end
                default: begin
                    cmd = $urandom_range(0, 1) ? CMD_POINT : CMD_NORMAL;
                    transform(cmd, pick_value(), pick_value(), pick_value());
                end
            endcase
        end
        i_valid <= 1'b0;
        while (sb.pending_vectors.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
